// ----- hdl/length_type_frame_deframer_assert.svh -----
// Assertion macros for the length/type frame deframer
`ifndef LENGTH_TYPE_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_TYPE_FRAME_DEFRAMER_ASSERT_SVH

// Check while out of reset
`define LTFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check at every edge, reset included
`define LTFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ltfd_pkg.sv -----
`default_nettype none

package ltfd_pkg;

  localparam logic [2:0] HdrBytes = 3'd5;
  localparam logic [2:0] HdrTypePos = HdrBytes - 3'd1;
  localparam logic [31:0] MaxFrameLenReset = 32'd65536;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic        last_of_frame;
    logic        length_error;
  } result_t;

  typedef struct packed {
    logic       error_seen;
    logic [2:0] header_count;
  } parse_status_t;

endpackage

`default_nettype wire

// ----- hdl/ltfd_parser.sv -----
`default_nettype none

module ltfd_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   accept,
  input  wire logic [7:0]             data_byte,
  output logic                        result_valid,
  output ltfd_pkg::result_t           result,
  output ltfd_pkg::parse_status_t     status
);

  logic [31:0] max_frame_len;
  logic [2:0]  header_count;
  logic [2:0]  header_count_next;
  logic [31:0] length_word;
  logic [31:0] length_word_next;
  logic [7:0]  type_byte;
  logic [7:0]  type_byte_next;
  logic [31:0] payload_count;
  logic [31:0] payload_count_next;
  logic [31:0] payload_count_inc;
  logic        error_seen;
  logic        error_seen_next;
  logic [4:0]  byte_shift;

  assign payload_count_inc = payload_count + 32'd1;
  assign byte_shift        = {header_count[1:0], 3'b000};

  always_comb begin
    header_count_next  = header_count;
    length_word_next   = length_word;
    type_byte_next     = type_byte;
    payload_count_next = payload_count;
    error_seen_next    = error_seen;
    result_valid       = 1'b0;
    result             = '{frame_type:    type_byte,
                           frame_length:  length_word,
                           payload_byte:  8'd0,
                           has_payload:   1'b0,
                           last_of_frame: 1'b0,
                           length_error:  1'b0};
    if (accept && !error_seen) begin
      if (header_count inside {[3'd0:3'd3]}) begin
        if (header_count == 3'd0) begin
          length_word_next = {24'd0, data_byte};
        end else begin
          length_word_next = length_word | ({24'd0, data_byte} << byte_shift);
        end
        header_count_next = header_count + 3'd1;
      end else if (header_count == ltfd_pkg::HdrTypePos) begin
        type_byte_next     = data_byte;
        payload_count_next = 32'd0;
        result.frame_type  = data_byte;
        if (length_word > max_frame_len) begin
          error_seen_next      = 1'b1;
          header_count_next    = ltfd_pkg::HdrBytes;
          result_valid         = 1'b1;
          result.last_of_frame = 1'b1;
          result.length_error  = 1'b1;
        end else if (length_word == 32'd0) begin
          header_count_next    = 3'd0;
          result_valid         = 1'b1;
          result.last_of_frame = 1'b1;
        end else begin
          header_count_next = ltfd_pkg::HdrBytes;
        end
      end else begin
        result_valid         = 1'b1;
        result.payload_byte  = data_byte;
        result.has_payload   = 1'b1;
        result.last_of_frame = (payload_count_inc == length_word);
        if (payload_count_inc == length_word) begin
          header_count_next  = 3'd0;
          payload_count_next = 32'd0;
        end else begin
          payload_count_next = payload_count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= ltfd_pkg::MaxFrameLenReset;
      header_count  <= 3'd0;
      length_word   <= 32'd0;
      type_byte     <= 8'd0;
      payload_count <= 32'd0;
      error_seen    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_frame_len <= cfg_data;
      end
      header_count  <= header_count_next;
      length_word   <= length_word_next;
      type_byte     <= type_byte_next;
      payload_count <= payload_count_next;
      error_seen    <= error_seen_next;
    end
  end

  assign status = '{error_seen: error_seen, header_count: header_count};

endmodule

`default_nettype wire

// ----- hdl/ltfd_out_buffer.sv -----
`default_nettype none

module ltfd_out_buffer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ltfd_pkg::result_t  push_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output ltfd_pkg::result_t       out_data,
  output logic                    full
);

  logic              main_valid;
  logic              skid_valid;
  ltfd_pkg::result_t main_data;
  ltfd_pkg::result_t skid_data;
  logic              pop;

  assign pop = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

endmodule

`default_nettype wire

// ----- hdl/length_type_frame_deframer.sv -----
`default_nettype none

// Deframes a byte stream of frames made of a 4-byte little-endian payload
// length, a type byte and the payload. One byte is taken per cycle while
// in_stall is low: the header and payload counters update in the same cycle
// the byte is transferred. Each payload byte comes out as one result carrying
// type, length and a last mark; an empty frame gives a single result without
// payload, and a length above max_frame_len gives one error result, after
// which all bytes are dropped until reset. Results pass through a two-entry
// output buffer (main and skid registers), so each result is registered before
// it reaches the output; in_stall rises only when both entries are held.
// max_frame_len resets to 65536 and is written through the cfg channel, which
// is always ready; write it only while the block is idle.

`include "length_type_frame_deframer_assert.svh"

module length_type_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_type,
  output logic [31:0]      frame_length,
  output logic [7:0]       payload_byte,
  output logic             has_payload,
  output logic             last_of_frame,
  output logic             length_error
);

  logic                    accept;
  logic                    result_valid;
  ltfd_pkg::result_t       result;
  ltfd_pkg::result_t       out_data;
  ltfd_pkg::parse_status_t status;
  logic                    full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  ltfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result       (result),
    .status       (status)
  );

  ltfd_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

  assign frame_type    = out_data.frame_type;
  assign frame_length  = out_data.frame_length;
  assign payload_byte  = out_data.payload_byte;
  assign has_payload   = out_data.has_payload;
  assign last_of_frame = out_data.last_of_frame;
  assign length_error  = out_data.length_error;

  `LTFD_ASSERT(a_full_implies_valid, in_stall |-> out_valid, "skid held without main entry")
  `LTFD_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid && !in_stall, "buffer not empty after reset")
  `LTFD_ASSERT(a_error_sticky, status.error_seen |=> status.error_seen, "error flag cleared")
  `LTFD_ASSERT(a_count_range, status.header_count <= ltfd_pkg::HdrBytes, "header count out of range")

endmodule

`default_nettype wire

// ----- bench/frame_checker.sv -----
`default_nettype none

module frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  frame_type,
  input  wire logic [31:0] frame_length,
  input  wire logic [7:0]  payload_byte,
  input  wire logic        has_payload,
  input  wire logic        last_of_frame,
  input  wire logic        length_error,
  output int               fail_count,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  ltfd_pkg::result_t expected_results[$];
  logic [2:0]  hdr_cnt;
  logic [31:0] len_word;
  logic [7:0]  kind_byte;
  logic [31:0] pay_cnt;
  logic        err_seen;
  logic [31:0] max_len;
  int          mismatches;
  int          n_checked;

  task automatic emit(input logic [7:0] pay, input logic has, input logic last,
                      input logic err);
    ltfd_pkg::result_t r;
    r.frame_type = kind_byte;
    r.frame_length = len_word;
    r.payload_byte = has ? pay : 8'h00;
    r.has_payload = has;
    r.last_of_frame = last;
    r.length_error = err;
    expected_results.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    if (err_seen) return;
    if (hdr_cnt < ltfd_pkg::HdrTypePos) begin
      if (hdr_cnt == 3'd0) len_word = '0;
      len_word = len_word | (32'(b) << (8 * hdr_cnt));
      hdr_cnt = hdr_cnt + 3'd1;
    end else if (hdr_cnt == ltfd_pkg::HdrTypePos) begin
      kind_byte = b;
      pay_cnt = '0;
      if (len_word > max_len) begin
        err_seen = 1'b1;
        hdr_cnt = ltfd_pkg::HdrBytes;
        emit(8'h00, 1'b0, 1'b1, 1'b1);
      end else if (len_word == 32'd0) begin
        hdr_cnt = 3'd0;
        emit(8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
        hdr_cnt = ltfd_pkg::HdrBytes;
      end
    end else begin
      pay_cnt = pay_cnt + 32'd1;
      if (pay_cnt == len_word) begin
        emit(b, 1'b1, 1'b1, 1'b0);
        hdr_cnt = 3'd0;
        pay_cnt = '0;
      end else begin
        emit(b, 1'b1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic check_result();
    ltfd_pkg::result_t got;
    ltfd_pkg::result_t exp;
    got = {frame_type, frame_length, payload_byte, has_payload, last_of_frame,
           length_error};
    n_checked++;
    if (expected_results.size() == 0) begin
      if (mismatches < 10)
        $display({"ERROR at %0t: unexpected result type=%02h len=%08h pay=%02h",
                  " has=%0b last=%0b err=%0b"},
                 $time, got.frame_type, got.frame_length, got.payload_byte,
                 got.has_payload, got.last_of_frame, got.length_error);
      mismatches++;
      return;
    end
    exp = expected_results.pop_front();
    if (got.frame_type !== exp.frame_type || got.frame_length !== exp.frame_length ||
        got.payload_byte !== exp.payload_byte || got.has_payload !== exp.has_payload ||
        got.last_of_frame !== exp.last_of_frame || got.length_error !== exp.length_error)
    begin
      if (mismatches < 10) begin
        $display("ERROR at %0t: result mismatch", $time);
        $display("  expected type=%02h len=%08h pay=%02h has=%0b last=%0b err=%0b",
                 exp.frame_type, exp.frame_length, exp.payload_byte,
                 exp.has_payload, exp.last_of_frame, exp.length_error);
        $display("  actual   type=%02h len=%08h pay=%02h has=%0b last=%0b err=%0b",
                 got.frame_type, got.frame_length, got.payload_byte,
                 got.has_payload, got.last_of_frame, got.length_error);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hdr_cnt = 3'd0;
      len_word = '0;
      kind_byte = '0;
      pay_cnt = '0;
      err_seen = 1'b0;
      max_len = ltfd_pkg::MaxFrameLenReset;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_len = cfg_data;
      if (in_valid && !in_stall) deframe_byte(data_byte);
      if (out_valid && !out_stall) check_result();
    end
    pending <= expected_results.size();
    fail_count <= mismatches;
    checked <= n_checked;
  end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  frame_type;
  logic [31:0] frame_length;
  logic [7:0]  payload_byte;
  logic        has_payload;
  logic        last_of_frame;
  logic        length_error;

  int          fail_count;
  int          pending;
  int          checked;

  int unsigned cycles = 0;
  int unsigned frames_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_used = 0;
  logic        tx_burst = 1'b0;
  logic        rx_burst = 1'b0;
  logic [31:0] limits[6];

  always #5 clk = ~clk;

  length_type_frame_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_type   (frame_type),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .has_payload  (has_payload),
    .last_of_frame(last_of_frame),
    .length_error (length_error)
  );

  frame_checker frame_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_type   (frame_type),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .has_payload  (has_payload),
    .last_of_frame(last_of_frame),
    .length_error (length_error),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always begin : result_sink
    int unsigned hold;
    if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
    hold = rx_burst ? 0 : $urandom_range(0, 9);
    if (hold != 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] len, input logic [7:0] kind);
    send_length(len);
    push_byte(kind);
    for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
    frames_sent++;
  endtask

  task automatic write_max_len(input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_frames(input logic [31:0] limit, input int unsigned nbytes);
    int unsigned start;
    logic [31:0] cap;
    logic [31:0] len;
    start = bytes_sent;
    cap = (limit < 32'd32) ? limit : 32'd32;
    while (bytes_sent - start < nbytes) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0: len = 32'd0;
        1: len = cap;
        2: len = (limit >= 32'd200) ? 32'($urandom_range(64, 200)) : cap;
        default: len = 32'($urandom_range(0, cap));
      endcase
      send_frame(len, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    data_byte <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(32'd0, 8'h00);
    send_length(32'd2);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    frames_sent++;

    // raise the limit between the length bytes and the type byte
    write_max_len(32'd3);
    send_length(32'd5);
    write_max_len(32'd5);
    push_byte(8'hA5);
    for (int i = 0; i < 5; i++) push_byte(8'($urandom_range(0, 255)));
    frames_sent++;

    limits[0] = 32'd0;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'd1;
    limits[3] = 32'd65536;
    limits[4] = 32'($urandom_range(2, 60));
    limits[5] = 32'd400;
    for (int p = 0; p < 6; p++) begin
      write_max_len(limits[p]);
      random_frames(limits[p], 200);
    end

    // oversized length, then everything is dropped
    write_max_len(32'hFFFF_FFFE);
    tx_burst = 1'b0;
    send_length(32'hFFFF_FFFF);
    push_byte(8'($urandom_range(0, 255)));
    frames_sent++;
    repeat (30) push_byte(8'($urandom_range(0, 255)));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d frames in %0d bytes under %0d limit settings (empty, boundary,",
             frames_sent, bytes_sent, settings_used + 1);
    $display("mid-header limit change, sticky length error); %0d results checked",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
